// ===== rtl/moesif_pkg.sv =====
// shared types and codes for the moesif snoop coherence block
// no dependencies; imported by moesif_cache and the top level of the block
package moesif_pkg;

  // line states, codes fixed by the coherence model
  typedef enum logic [2:0] {
    COH_M = 3'd0,
    COH_O = 3'd1,
    COH_E = 3'd2,
    COH_S = 3'd3,
    COH_I = 3'd4,
    COH_F = 3'd5
  } coh_e;

  // operations one cache bank performs on its ways in a cycle
  typedef enum logic [2:0] {
    OP_NONE          = 3'd0,
    OP_TOUCH         = 3'd1,
    OP_WRITE_HIT     = 3'd2,
    OP_FILL          = 3'd3,
    OP_SNP_READ      = 3'd4,
    OP_SNP_KILL_S    = 3'd5,
    OP_SNP_KILL_SHRD = 3'd6,
    OP_SNP_KILL_ALL  = 3'd7
  } cache_op_e;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef struct packed {
    logic [1:0]  core_id;
    logic        kind;
    logic [15:0] line_tag;
  } req_t;

  typedef struct packed {
    logic        was_hit;
    logic [1:0]  writebacks_now;
    logic        broadcast_now;
    logic        transfer_now;
    logic [31:0] total_hits;
    logic [31:0] total_misses;
    logic [31:0] total_writebacks;
    logic [31:0] total_broadcasts;
    logic [31:0] total_transfers;
  } rsp_t;

  typedef struct packed {
    logic       was_hit;
    logic [1:0] writebacks_now;
    logic       broadcast_now;
    logic       transfer_now;
  } evt_t;

  typedef struct packed {
    cache_op_e op;
    coh_e      fill_state;
    logic      fill_dirty;
  } cache_cmd_t;

  typedef struct packed {
    logic hit;
    coh_e state;
    logic victim_dirty;
  } cache_look_t;

endpackage

// ===== rtl/moesif_cache.sv =====
// one core's fully associative cache: per-way state, tag, lru rank, dirty mark
// depends on moesif_pkg
module moesif_cache #(
  parameter int NUM_WAYS = 4,
  parameter int TAG_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [TAG_BITS-1:0]      tag_i,
  input  moesif_pkg::cache_cmd_t   cmd_i,
  output moesif_pkg::cache_look_t  look_o
);
  import moesif_pkg::*;

  localparam int RW = $clog2(NUM_WAYS);

  coh_e                state_q [NUM_WAYS];
  coh_e                state_d [NUM_WAYS];
  logic [RW-1:0]       rank_q  [NUM_WAYS];
  logic [RW-1:0]       rank_d  [NUM_WAYS];
  logic [TAG_BITS-1:0] tag_q   [NUM_WAYS];
  logic [NUM_WAYS-1:0] dirty_q, dirty_d;

  logic          hit;
  logic [RW-1:0] hit_way;
  logic          inv_found, lru_found;
  logic [RW-1:0] inv_way, lru_way, victim, tgt;
  logic          do_touch;
  logic [RW-1:0] old_rank;

  // lookup and victim search
  always_comb begin
    hit       = 1'b0;
    hit_way   = '0;
    inv_found = 1'b0;
    inv_way   = '0;
    lru_found = 1'b0;
    lru_way   = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!hit && state_q[w] != COH_I && tag_q[w] == tag_i) begin
        hit     = 1'b1;
        hit_way = RW'(w);
      end
      if (!inv_found && state_q[w] == COH_I) begin
        inv_found = 1'b1;
        inv_way   = RW'(w);
      end
      if (!lru_found && rank_q[w] == '0) begin
        lru_found = 1'b1;
        lru_way   = RW'(w);
      end
    end
    victim = inv_found ? inv_way : (lru_found ? lru_way : '0);
    tgt    = (cmd_i.op == OP_FILL) ? victim : hit_way;
  end

  assign look_o.hit          = hit;
  assign look_o.state        = hit ? state_q[hit_way] : COH_I;
  assign look_o.victim_dirty = dirty_q[victim];

  // state and dirty update
  always_comb begin
    state_d  = state_q;
    dirty_d  = dirty_q;
    do_touch = 1'b0;
    unique case (cmd_i.op)
      OP_NONE: ;
      OP_TOUCH: do_touch = 1'b1;
      OP_WRITE_HIT: begin
        do_touch = 1'b1;
        if (state_q[tgt] != COH_M) begin
          state_d[tgt] = COH_M;
          dirty_d[tgt] = 1'b1;
        end
      end
      OP_FILL: begin
        do_touch     = 1'b1;
        state_d[tgt] = cmd_i.fill_state;
        dirty_d[tgt] = cmd_i.fill_dirty;
      end
      OP_SNP_READ: begin
        if (hit && state_q[tgt] == COH_M) state_d[tgt] = COH_O;
        if (hit && state_q[tgt] == COH_E) state_d[tgt] = COH_F;
      end
      OP_SNP_KILL_S: begin
        if (hit && state_q[tgt] == COH_S) state_d[tgt] = COH_I;
      end
      OP_SNP_KILL_SHRD: begin
        if (hit && (state_q[tgt] == COH_O || state_q[tgt] == COH_F ||
                    state_q[tgt] == COH_S)) state_d[tgt] = COH_I;
      end
      OP_SNP_KILL_ALL: begin
        if (hit && (state_q[tgt] == COH_O || state_q[tgt] == COH_M ||
                    state_q[tgt] == COH_F || state_q[tgt] == COH_S)) state_d[tgt] = COH_I;
      end
    endcase
  end

  // lru touch: target goes to top, ranks above it drop by one
  always_comb begin
    old_rank = rank_q[tgt];
    rank_d   = rank_q;
    if (do_touch) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (rank_q[w] > old_rank) begin
          rank_d[w] = RW'(rank_q[w] - 1'b1);
        end else if (rank_q[w] == old_rank) begin
          rank_d[w] = RW'(NUM_WAYS - 1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        state_q[w] <= COH_I;
        rank_q[w]  <= RW'(w);
      end
      dirty_q <= '0;
    end else begin
      state_q <= state_d;
      rank_q  <= rank_d;
      dirty_q <= dirty_d;
    end
  end

  // invalid ways never match, so tags need no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_FILL) begin
      tag_q[victim] <= tag_i;
    end
  end

endmodule

// ===== rtl/moesif_stats.sv =====
// one saturating running total, shown masked or zero extended to 32 bits
// depends on nothing outside this file
module moesif_stats #(
  parameter int COUNT_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [1:0]  inc_i,
  output logic [31:0] total_o
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [COUNT_BITS:0]   sum;

  always_comb begin
    sum = {1'b0, cnt_q} + (COUNT_BITS + 1)'(inc_i);
    if (sum > {1'b0, CNT_MAX}) begin
      cnt_d = CNT_MAX;
    end else begin
      cnt_d = sum[COUNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  if (COUNT_BITS >= 32) begin : g_wide
    assign total_o = cnt_q[31:0];
  end else begin : g_narrow
    assign total_o = {(32 - COUNT_BITS)'(0), cnt_q};
  end

endmodule

// ===== rtl/moesif_snoop_coherence_model_core.sv =====
// top level of the moesif snooping coherence model
// depends on moesif_pkg, moesif_cache and moesif_stats
//
// Snooping MOESIF coherence model for NUM_CORES cores, each holding a
// NUM_WAYS-way fully associative cache with lru replacement. Each beat on
// the request side is one read or write by one core to one line tag. A
// beat is taken at every clock edge where start_i is high and busy_o is
// low; busy_o stays low, so a new access can be issued every cycle. The
// access is captured in an input register, then in the following cycle
// all tag compares in every core, the snoop actions on the other cores and
// the install in the requesting core are resolved in one pass and written
// to the way registers. The result register loads at the same edge as the
// way registers, so the result beat is on result_o, marked by result_valid_o,
// for a single cycle; the receiver cannot stall it, so it must take every
// beat. Throughput is one access per cycle, set by the single combinational
// pass over all ways between the input register and the way and result
// registers.
// A core_id of NUM_CORES or more still produces a result beat, with all
// event fields zero and unchanged totals. Totals saturate at their
// COUNT_BITS maximum and show their low 32 bits.
module moesif_snoop_coherence_model_core #(
  parameter int NUM_CORES  = 4,
  parameter int NUM_WAYS   = 4,
  parameter int TAG_BITS   = 16,
  parameter int COUNT_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  moesif_pkg::req_t  req_i,
  output logic              result_valid_o,
  output moesif_pkg::rsp_t  result_o
);
  import moesif_pkg::*;

  // input register
  logic in_valid_q;
  req_t in_q;

  // per-core lookup results and commands
  cache_look_t         look [NUM_CORES];
  cache_cmd_t          cmd  [NUM_CORES];
  logic [31:0]         tag_ext;
  logic [TAG_BITS-1:0] tag;

  // access decode
  logic      act;
  logic      req_hit, req_vdirty;
  coh_e      req_state;
  logic      any_o, any_supply, any_dirty;
  cache_op_e req_op, oth_op;
  coh_e      fill_state;
  logic      fill_dirty;
  logic      ev_hit, ev_miss, ev_bc, ev_tr;
  logic      wb_snoop, wb_victim;
  logic [1:0] ev_wb;

  // result register
  logic result_valid_q;
  evt_t evt_q;

  logic [31:0] tot_hits, tot_misses, tot_wbs, tot_bcs, tot_trs;

  // never stalls: one access per cycle
  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      in_q <= req_i;
    end
  end

  // only the low TAG_BITS of the line tag take part
  assign tag_ext = 32'(in_q.line_tag);
  assign tag     = tag_ext[TAG_BITS-1:0];

  for (genvar c = 0; c < NUM_CORES; c++) begin : g_core
    moesif_cache #(
      .NUM_WAYS (NUM_WAYS),
      .TAG_BITS (TAG_BITS)
    ) u_cache (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tag_i  (tag),
      .cmd_i  (cmd[c]),
      .look_o (look[c])
    );
  end

  // requester view and what the other cores hold
  always_comb begin
    act        = in_valid_q && (32'(in_q.core_id) < 32'(NUM_CORES));
    req_hit    = 1'b0;
    req_state  = COH_I;
    req_vdirty = 1'b0;
    any_o      = 1'b0;
    any_supply = 1'b0;
    any_dirty  = 1'b0;
    for (int c = 0; c < NUM_CORES; c++) begin
      if (32'(c) == 32'(in_q.core_id)) begin
        req_hit    = look[c].hit;
        req_state  = look[c].state;
        req_vdirty = look[c].victim_dirty;
      end else if (look[c].hit) begin
        if (look[c].state == COH_O) any_o = 1'b1;
        if (look[c].state == COH_M || look[c].state == COH_O ||
            look[c].state == COH_E || look[c].state == COH_F) any_supply = 1'b1;
        if (look[c].state == COH_M || look[c].state == COH_O) any_dirty = 1'b1;
      end
    end
  end

  // protocol decision for this access
  always_comb begin
    req_op     = OP_NONE;
    oth_op     = OP_NONE;
    fill_state = COH_E;
    fill_dirty = 1'b0;
    ev_hit     = 1'b0;
    ev_miss    = 1'b0;
    ev_bc      = 1'b0;
    ev_tr      = 1'b0;
    wb_snoop   = 1'b0;
    wb_victim  = 1'b0;
    if (act) begin
      if (in_q.kind == KIND_READ) begin
        if (req_hit) begin
          // read hit: broadcast unless exclusive, state unchanged
          ev_hit = 1'b1;
          ev_bc  = (req_state != COH_E);
          req_op = OP_TOUCH;
        end else begin
          // read miss: others downgrade and may supply the line
          ev_miss    = 1'b1;
          ev_bc      = 1'b1;
          ev_tr      = any_supply;
          oth_op     = OP_SNP_READ;
          req_op     = OP_FILL;
          fill_state = any_supply ? COH_S : COH_E;
          fill_dirty = any_dirty;
          wb_victim  = req_vdirty;
        end
      end else if (req_hit) begin
        ev_hit = 1'b1;
        req_op = OP_WRITE_HIT;
        if (req_state == COH_O) begin
          // owner upgrade: its own writeback, shared copies dropped
          ev_bc    = 1'b1;
          wb_snoop = 1'b1;
          oth_op   = OP_SNP_KILL_S;
        end else if (req_state != COH_E && req_state != COH_M) begin
          // shared or forward upgrade: other sharers and owner dropped
          ev_bc    = 1'b1;
          wb_snoop = any_o;
          oth_op   = OP_SNP_KILL_SHRD;
        end
      end else begin
        // write miss: other M, O, F and S copies invalidated, installed modified
        ev_miss    = 1'b1;
        ev_bc      = 1'b1;
        wb_snoop   = any_o;
        oth_op     = OP_SNP_KILL_ALL;
        req_op     = OP_FILL;
        fill_state = COH_M;
        fill_dirty = 1'b1;
        wb_victim  = req_vdirty;
      end
    end
    ev_wb = {1'b0, wb_snoop} + {1'b0, wb_victim};
  end

  always_comb begin
    for (int c = 0; c < NUM_CORES; c++) begin
      cmd[c].op         = (act && 32'(c) == 32'(in_q.core_id)) ? req_op : oth_op;
      cmd[c].fill_state = fill_state;
      cmd[c].fill_dirty = fill_dirty;
    end
  end

  // running totals update on the same edge as the result register, so
  // during the result beat they already include that access
  moesif_stats #(.COUNT_BITS(COUNT_BITS)) u_hits (
    .clk_i (clk_i), .rst_ni (rst_ni), .inc_i ({1'b0, ev_hit}), .total_o (tot_hits)
  );
  moesif_stats #(.COUNT_BITS(COUNT_BITS)) u_misses (
    .clk_i (clk_i), .rst_ni (rst_ni), .inc_i ({1'b0, ev_miss}), .total_o (tot_misses)
  );
  moesif_stats #(.COUNT_BITS(COUNT_BITS)) u_wbs (
    .clk_i (clk_i), .rst_ni (rst_ni), .inc_i (ev_wb), .total_o (tot_wbs)
  );
  moesif_stats #(.COUNT_BITS(COUNT_BITS)) u_bcs (
    .clk_i (clk_i), .rst_ni (rst_ni), .inc_i ({1'b0, ev_bc}), .total_o (tot_bcs)
  );
  moesif_stats #(.COUNT_BITS(COUNT_BITS)) u_trs (
    .clk_i (clk_i), .rst_ni (rst_ni), .inc_i ({1'b0, ev_tr}), .total_o (tot_trs)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      evt_q.was_hit        <= ev_hit;
      evt_q.writebacks_now <= ev_wb;
      evt_q.broadcast_now  <= ev_bc;
      evt_q.transfer_now   <= ev_tr;
    end
  end

  assign result_valid_o = result_valid_q;

  always_comb begin
    result_o.was_hit          = evt_q.was_hit;
    result_o.writebacks_now   = evt_q.writebacks_now;
    result_o.broadcast_now    = evt_q.broadcast_now;
    result_o.transfer_now     = evt_q.transfer_now;
    result_o.total_hits       = tot_hits;
    result_o.total_misses     = tot_misses;
    result_o.total_writebacks = tot_wbs;
    result_o.total_broadcasts = tot_bcs;
    result_o.total_transfers  = tot_trs;
  end

`ifndef ASSERT_OFF
  // every captured access yields exactly one result beat in the following cycle
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q |=> result_valid_o)
    else $error("captured access produced no result beat");

  // a supplied line only happens on a miss
  a_transfer_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.transfer_now |-> !result_o.was_hit)
    else $error("cache transfer reported on a hit");

  // totals move only when an access is resolved
  a_totals_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |=> $stable(result_o.total_hits) && $stable(result_o.total_misses)
                    && $stable(result_o.total_writebacks))
    else $error("running totals changed without an access");
`endif

endmodule
